>>> hdl/srt_pkg.sv
// Shared types and constants of the scrub region table.
package srt_pkg;

    localparam int FRAME_BITS = 28;
    localparam int FRAME_W    = 28;
    localparam int PAGES_W    = 29;
    localparam int SUM_W      = 30;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 96;

    localparam logic [SUM_W-1:0] FRAME_LIMIT = SUM_W'(1) << FRAME_BITS;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_SPAN = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [FRAME_W-1:0] first;
        logic [PAGES_W-1:0] length;
    } t_entry;

endpackage

>>> hdl/scrub_region_table_core.sv
// Scrub region table: sorted region list in a RAM with a scan/shift sequencer.
// A trivial request needs no RAM access; a scan reads each entry visited, and an insert,
// split or removal shifts entries one at a time through the RAM; a span that wraps rescans from the first entry.
// One request is in flight at a time; the result register frees the input side.
// Synchronous active-low reset empties the table and clears total and disable flag.
module scrub_region_table_core #(
    parameter int MAX_REGIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // page_frame[27:0], page_count[56:28]
    input  logic [srt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[1:0], span_start[29:2], span_pages[58:30], table_end[59],
    // total_pages[88:60], scrub_off[89]
    output logic [srt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import srt_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EV, S_RD2, S_NB, S_OPN, S_OPW, S_CLN, S_CLW, S_OUT
    } t_state;

    t_state               r_state;
    t_entry               r_mem [MAX_REGIONS];
    t_entry               r_rd;
    logic                 r_we;
    logic [IW-1:0]        r_wa;
    t_entry               r_wd;
    logic [IW-1:0]        n_ra;

    t_action              r_act;
    logic [FRAME_W-1:0]   r_a;
    logic [PAGES_W-1:0]   r_n;
    logic [CW-1:0]        r_cnt, r_idx, r_k, r_ins;
    logic                 r_wrap;
    logic [FRAME_W-1:0]   r_s;
    logic [PAGES_W-1:0]   r_len;
    t_entry               r_new;
    logic [PAGES_W-1:0]   r_total;
    logic                 r_off;
    t_status              r_sts;
    logic [FRAME_W-1:0]   r_sp_start;
    logic [PAGES_W-1:0]   r_sp_pages;
    logic                 r_sp_end;
    logic                 r_ov;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [FRAME_W-1:0]   in_a;
    logic [PAGES_W-1:0]   in_n;
    logic [SUM_W-1:0]     in_stop;
    logic [SUM_W-1:0]     a30, n30, stop30, s30, e30, cur30, rest30, len30;
    logic [CW-1:0]        idx_nx;

    assign in_a    = i_s_axis_tdata[FRAME_W-1:0];
    assign in_n    = i_s_axis_tdata[FRAME_W+PAGES_W-1:FRAME_W];
    assign in_stop = SUM_W'(in_a) + SUM_W'(in_n);

    assign a30    = SUM_W'(r_a);
    assign n30    = SUM_W'(r_n);
    assign stop30 = a30 + n30;
    assign s30    = SUM_W'(r_rd.first);
    assign e30    = s30 + SUM_W'(r_rd.length);
    assign cur30  = (r_wrap || a30 < s30) ? s30 : a30;
    assign rest30 = e30 - cur30;
    assign len30  = (n30 > rest30) ? rest30 : n30;
    assign idx_nx = r_idx + CW'(1);

    always_comb begin
        case (r_state)
            S_RD:    n_ra = r_idx[IW-1:0];
            S_RD2:   n_ra = idx_nx[IW-1:0];
            S_OPN:   n_ra = IW'(r_k - CW'(1));
            S_CLN:   n_ra = IW'(r_k + CW'(1));
            default: n_ra = r_idx[IW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_wa] <= r_wd;
        end
        r_rd <= r_mem[n_ra];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_we    <= 1'b0;
            r_cnt   <= '0;
            r_total <= '0;
            r_off   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || i_m_axis_tready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_act      <= t_action'(i_s_axis_tuser);
                        r_a        <= in_a;
                        r_n        <= in_n;
                        r_idx      <= '0;
                        r_wrap     <= 1'b0;
                        r_sp_start <= '0;
                        r_sp_pages <= '0;
                        r_sp_end   <= 1'b0;
                        case (t_action'(i_s_axis_tuser))
                            ACT_ADD: begin
                                if (in_n == '0) begin
                                    r_sts   <= ST_OK;
                                    r_state <= S_OUT;
                                end else if (in_stop > FRAME_LIMIT) begin
                                    r_sts   <= ST_BAD;
                                    r_state <= S_OUT;
                                end else begin
                                    r_sts   <= ST_OK;
                                    r_state <= S_RD;
                                end
                            end
                            ACT_DEL: begin
                                r_sts   <= ST_OK;
                                r_state <= (in_n == '0) ? S_OUT : S_RD;
                            end
                            ACT_SPAN: begin
                                if (r_cnt == '0) begin
                                    r_sts   <= ST_EMPTY;
                                    r_state <= S_OUT;
                                end else begin
                                    r_sts   <= ST_OK;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_sts   <= ST_OK;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (r_idx >= r_cnt) begin
                        case (r_act)
                            ACT_ADD: begin
                                if (r_cnt >= CW'(MAX_REGIONS)) begin
                                    r_sts   <= ST_FULL;
                                    r_state <= S_OUT;
                                end else begin
                                    r_ins   <= r_idx;
                                    r_k     <= r_cnt;
                                    r_new   <= '{first: r_a, length: r_n};
                                    r_total <= r_total + r_n;
                                    r_state <= S_OPN;
                                end
                            end
                            ACT_SPAN: begin
                                r_wrap <= 1'b1;
                                r_idx  <= '0;
                            end
                            default: begin
                                r_sts   <= ST_BAD;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_state <= S_EV;
                    end
                end
                S_EV: begin
                    case (r_act)
                        ACT_ADD: begin
                            if (a30 > e30) begin
                                r_idx   <= idx_nx;
                                r_state <= S_RD;
                            end else if (stop30 == s30) begin
                                r_we    <= 1'b1;
                                r_wa    <= r_idx[IW-1:0];
                                r_wd    <= '{first: r_a, length: r_rd.length + r_n};
                                r_total <= r_total + r_n;
                                r_state <= S_OUT;
                            end else if (a30 == e30) begin
                                if (idx_nx < r_cnt) begin
                                    r_s     <= r_rd.first;
                                    r_len   <= r_rd.length;
                                    r_state <= S_RD2;
                                end else begin
                                    r_we    <= 1'b1;
                                    r_wa    <= r_idx[IW-1:0];
                                    r_wd    <= '{first: r_rd.first,
                                                 length: r_rd.length + r_n};
                                    r_total <= r_total + r_n;
                                    r_state <= S_OUT;
                                end
                            end else if (stop30 > s30) begin
                                r_sts   <= ST_BAD;
                                r_state <= S_OUT;
                            end else if (r_cnt >= CW'(MAX_REGIONS)) begin
                                r_sts   <= ST_FULL;
                                r_state <= S_OUT;
                            end else begin
                                r_ins   <= r_idx;
                                r_k     <= r_cnt;
                                r_new   <= '{first: r_a, length: r_n};
                                r_total <= r_total + r_n;
                                r_state <= S_OPN;
                            end
                        end
                        ACT_DEL: begin
                            if (!(a30 >= s30 && a30 < e30)) begin
                                r_idx   <= idx_nx;
                                r_state <= S_RD;
                            end else if (stop30 > e30) begin
                                r_sts   <= ST_BAD;
                                r_state <= S_OUT;
                            end else if (!(a30 != s30 && stop30 != e30)
                                         || r_cnt < CW'(MAX_REGIONS)) begin
                                r_total <= r_total - r_n;
                                if (r_total == r_n) begin
                                    r_off <= 1'b1;
                                end
                                if (a30 == s30) begin
                                    if (r_n == r_rd.length) begin
                                        r_k     <= r_idx;
                                        r_state <= S_CLN;
                                    end else begin
                                        r_we    <= 1'b1;
                                        r_wa    <= r_idx[IW-1:0];
                                        r_wd    <= '{first: FRAME_W'(s30 + n30),
                                                     length: r_rd.length - r_n};
                                        r_state <= S_OUT;
                                    end
                                end else if (stop30 == e30) begin
                                    r_we    <= 1'b1;
                                    r_wa    <= r_idx[IW-1:0];
                                    r_wd    <= '{first: r_rd.first,
                                                 length: r_rd.length - r_n};
                                    r_state <= S_OUT;
                                end else begin
                                    r_we    <= 1'b1;
                                    r_wa    <= r_idx[IW-1:0];
                                    r_wd    <= '{first: r_rd.first,
                                                 length: PAGES_W'(a30 - s30)};
                                    r_new   <= '{first: FRAME_W'(stop30),
                                                 length: PAGES_W'(e30 - stop30)};
                                    r_ins   <= idx_nx;
                                    r_k     <= r_cnt;
                                    r_state <= S_OPN;
                                end
                            end else begin
                                r_sts   <= ST_FULL;
                                r_state <= S_OUT;
                            end
                        end
                        default: begin
                            if (r_wrap || a30 < e30) begin
                                r_sp_start <= FRAME_W'(cur30);
                                r_sp_pages <= PAGES_W'(len30);
                                r_sp_end   <= (idx_nx == r_cnt) && (len30 == rest30);
                                r_state    <= S_OUT;
                            end else begin
                                r_idx   <= idx_nx;
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_RD2: r_state <= S_NB;
                S_NB: begin
                    if (stop30 > SUM_W'(r_rd.first)) begin
                        r_sts   <= ST_BAD;
                        r_state <= S_OUT;
                    end else begin
                        r_total <= r_total + r_n;
                        r_we    <= 1'b1;
                        r_wa    <= r_idx[IW-1:0];
                        if (stop30 == SUM_W'(r_rd.first)) begin
                            r_wd    <= '{first: r_s, length: r_len + r_n + r_rd.length};
                            r_k     <= idx_nx;
                            r_state <= S_CLN;
                        end else begin
                            r_wd    <= '{first: r_s, length: r_len + r_n};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OPN: begin
                    if (r_k == r_ins) begin
                        r_we    <= 1'b1;
                        r_wa    <= r_ins[IW-1:0];
                        r_wd    <= r_new;
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_we    <= 1'b0;
                        r_state <= S_OPW;
                    end
                end
                S_OPW: begin
                    r_we    <= 1'b1;
                    r_wa    <= r_k[IW-1:0];
                    r_wd    <= r_rd;
                    r_k     <= r_k - CW'(1);
                    r_state <= S_OPN;
                end
                S_CLN: begin
                    r_we <= 1'b0;
                    if (r_k + CW'(1) < r_cnt) begin
                        r_state <= S_CLW;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_CLW: begin
                    r_we    <= 1'b1;
                    r_wa    <= r_k[IW-1:0];
                    r_wd    <= r_rd;
                    r_k     <= r_k + CW'(1);
                    r_state <= S_CLN;
                end
                S_OUT: begin
                    r_we <= 1'b0;
                    if (!r_ov || i_m_axis_tready) begin
                        r_odata <= {6'd0, r_off, r_total, r_sp_end, r_sp_pages,
                                    r_sp_start, r_sts};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/srt_checker.sv
// Port-level checks of the scrub region table, bound to the top level.
module srt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [srt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import srt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[89] |=> !o_m_axis_tvalid || o_m_axis_tdata[89])
        else $error("scrub_off cleared");

    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[59] |-> o_m_axis_tdata[1:0] == ST_OK)
        else $error("table_end with failing status");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == ST_EMPTY
        |-> o_m_axis_tdata[59:2] == '0)
        else $error("span fields set on empty table");

endmodule

bind scrub_region_table_core srt_checker u_srt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> tb/scrub_region_table_checker.sv
`timescale 1ns / 100ps
// Checker for the scrub region table: tracks table state, predicts each result and compares.
module scrub_region_table_checker #(
    parameter int MAX_REGIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [srt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [1:0]                      i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [srt_pkg::OUT_DATA_W-1:0]  i_m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_region_count
);
    import srt_pkg::*;

    // highest field first, so status lands in the low bits
    typedef struct packed {
        logic               scrub_off;
        logic [PAGES_W-1:0] total_pages;
        logic               table_end;
        logic [PAGES_W-1:0] span_pages;
        logic [FRAME_W-1:0] span_start;
        t_status            status;
    } t_result;

    logic [63:0] tbl_first [MAX_REGIONS];
    logic [63:0] tbl_len   [MAX_REGIONS];
    int          tbl_used;
    logic [63:0] page_sum;
    logic        scrub_disabled;
    t_result     expected_q[$];
    int          fails;

    assign o_fail_count   = fails;
    assign o_pending      = expected_q.size();
    assign o_region_count = tbl_used;

    function automatic void open_gap(int at);
        for (int k = tbl_used; k > at; k--) begin
            tbl_first[k] = tbl_first[k-1];
            tbl_len[k]   = tbl_len[k-1];
        end
        tbl_used++;
    endfunction

    function automatic void close_gap(int at);
        for (int k = at; k + 1 < tbl_used; k++) begin
            tbl_first[k] = tbl_first[k+1];
            tbl_len[k]   = tbl_len[k+1];
        end
        tbl_used--;
    endfunction

    function automatic t_status add_region(logic [63:0] a, logic [63:0] n);
        logic [63:0] stop, s, e;
        int i;
        stop = a + n;
        if (n == 0) return ST_OK;
        if (stop > (64'd1 << FRAME_BITS)) return ST_BAD;
        for (i = 0; i < tbl_used; i++) begin
            s = tbl_first[i];
            e = s + tbl_len[i];
            if (a > e) continue;
            if (stop == s) begin
                tbl_first[i] = a;
                tbl_len[i] += n;
                page_sum += n;
                return ST_OK;
            end
            if (a == e) begin
                if (i + 1 < tbl_used) begin
                    if (stop > tbl_first[i+1]) return ST_BAD;
                    if (stop == tbl_first[i+1]) begin
                        tbl_len[i] += n + tbl_len[i+1];
                        close_gap(i + 1);
                        page_sum += n;
                        return ST_OK;
                    end
                end
                tbl_len[i] += n;
                page_sum += n;
                return ST_OK;
            end
            if (stop > s) return ST_BAD;
            break;
        end
        if (tbl_used >= MAX_REGIONS) return ST_FULL;
        open_gap(i);
        tbl_first[i] = a;
        tbl_len[i]   = n;
        page_sum += n;
        return ST_OK;
    endfunction

    function automatic t_status delete_range(logic [63:0] a, logic [63:0] n);
        logic [63:0] s, e;
        int i;
        bit hit;
        s = 0;
        e = 0;
        hit = 0;
        if (n == 0) return ST_OK;
        for (i = 0; i < tbl_used; i++) begin
            s = tbl_first[i];
            e = s + tbl_len[i];
            if (a >= s && a < e) begin
                hit = 1;
                break;
            end
        end
        if (!hit || a + n > e) return ST_BAD;
        if (a == s) begin
            if (n == tbl_len[i]) close_gap(i);
            else begin
                tbl_first[i] += n;
                tbl_len[i]   -= n;
            end
        end else if (a + n == e) begin
            tbl_len[i] -= n;
        end else begin
            if (tbl_used >= MAX_REGIONS) return ST_FULL;
            open_gap(i + 1);
            tbl_first[i+1] = a + n;
            tbl_len[i+1]   = e - (a + n);
            tbl_len[i]     = a - s;
        end
        page_sum -= n;
        if (page_sum == 0) scrub_disabled = 1;
        return ST_OK;
    endfunction

    function automatic t_result predict_result(t_action act, logic [63:0] a, logic [63:0] n);
        t_result r;
        logic [63:0] e;
        int i;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_ADD) r.status = add_region(a, n);
        else if (act == ACT_DEL) r.status = delete_range(a, n);
        else if (act == ACT_SPAN) begin
            if (tbl_used == 0) r.status = ST_EMPTY;
            else begin
                for (i = 0; i < tbl_used; i++) begin
                    if (a < tbl_first[i]) begin
                        a = tbl_first[i];
                        break;
                    end
                    if (a < tbl_first[i] + tbl_len[i]) break;
                end
                if (i >= tbl_used) begin
                    i = 0;
                    a = tbl_first[0];
                end
                e = tbl_first[i] + tbl_len[i];
                if (n > e - a) n = e - a;
                r.span_start = a[FRAME_W-1:0];
                r.span_pages = n[PAGES_W-1:0];
                r.table_end  = (i + 1 == tbl_used) && (a + n == e);
            end
        end
        r.total_pages = page_sum[PAGES_W-1:0];
        r.scrub_off   = scrub_disabled;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r, got_r;
        if (!i_rst_n) begin
            tbl_used = 0;
            page_sum = 0;
            scrub_disabled = 0;
            expected_q.delete();
            fails = 0;
            o_result_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_result_count++;
                got_r = i_m_axis_tdata[89:0];
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %h", got_r);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) begin
                        fails++;
                        if (fails <= 10)
                            $display({"mismatch: st %0d/%0d start %h/%h pages %h/%h",
                                      " end %b/%b tot %h/%h off %b/%b"},
                                exp_r.status, got_r.status, exp_r.span_start, got_r.span_start,
                                exp_r.span_pages, got_r.span_pages, exp_r.table_end,
                                got_r.table_end, exp_r.total_pages, got_r.total_pages,
                                exp_r.scrub_off, got_r.scrub_off);
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(predict_result(t_action'(i_s_axis_tuser),
                    {36'd0, i_s_axis_tdata[27:0]}, {35'd0, i_s_axis_tdata[56:28]}));
        end
    end
endmodule

>>> tb/tb_scrub_region_table_core.sv
`timescale 1ns / 100ps
// Testbench top: drives region adds, deletes, span and no-op requests into the core, gives the verdict.
module tb_scrub_region_table_core;
    import srt_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [1:0]             s_tuser;
    logic [OUT_DATA_W-1:0]  m_tdata;
    int                     fail_count, pending, result_count, used;
    int                     cycle_count;
    bit                     idle_mode;
    bit                     hold_off;
    int                     req_count;

    scrub_region_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    scrub_region_table_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_region_count(used)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall bursts, or a long hold-off on request
    initial begin
        int burst;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end else if (idle_mode && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_req(t_action act, logic [27:0] frame, logic [28:0] count);
        int gap;
        if (idle_mode && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, count, frame};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        req_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int r;
        logic [27:0] f;
        logic [28:0] n;
        cycle_count = 0;
        idle_mode   = 1;
        hold_off    = 0;
        req_count   = 0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_NONE;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send_req(ACT_SPAN, 28'd5, 29'd10);
        send_req(ACT_DEL, 28'd5, 29'd10);
        send_req(ACT_ADD, 28'd100, 29'd0);
        send_req(ACT_ADD, 28'hFFFFFFF, 29'd2);
        send_req(ACT_ADD, 28'hFFFFFFF, 29'd1);
        send_req(ACT_ADD, 28'd0, 29'h10000000);
        send_req(ACT_DEL, 28'd0, 29'h10000000);
        send_req(ACT_ADD, 28'd100, 29'd50);
        send_req(ACT_ADD, 28'd90, 29'd20);
        send_req(ACT_ADD, 28'd200, 29'd50);
        send_req(ACT_ADD, 28'd150, 29'd50);
        send_req(ACT_ADD, 28'd80, 29'd20);
        send_req(ACT_ADD, 28'd300, 29'd10);
        send_req(ACT_DEL, 28'd80, 29'd5);
        send_req(ACT_DEL, 28'd300, 29'd10);
        send_req(ACT_DEL, 28'd240, 29'd5);
        send_req(ACT_DEL, 28'd120, 29'd10);
        send_req(ACT_DEL, 28'd110, 29'd100);
        send_req(ACT_SPAN, 28'd0, 29'h1FFFFFFF);
        send_req(ACT_SPAN, 28'd125, 29'd3);
        send_req(ACT_SPAN, 28'hFFFFFFF, 29'd1000);
        send_req(ACT_NONE, 28'hFFFFFFF, 29'h1FFFFFFF);
        for (int k = 0; k < 17; k++) send_req(ACT_ADD, 28'd1000 + 28'(k * 10), 29'd3);
        send_req(ACT_DEL, 28'd1001, 29'd1);
        drain();

        // long receiver hold-off while requests keep coming
        hold_off = 1;
        for (int k = 0; k < 10; k++) send_req(ACT_SPAN, 28'(k * 100), 29'd7);
        drain();

        for (int k = 0; k < 400; k++) begin
            if (k == 330) idle_mode = 0;
            if (k == 200) begin
                drain();
                // delete the whole frame range, which wipes the table only if one region covers it all
                send_req(ACT_DEL, 28'd0, 29'h10000000);
            end
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                f = 28'($urandom);
                n = 29'($urandom);
            end else begin
                f = 28'(($urandom_range(0, 63)) * 64) | (($urandom_range(0, 7) == 0)
                    ? 28'h8000000 : 28'h0);
                n = 29'($urandom_range(0, 70));
            end
            if (k % 80 == 79) f = 28'hFFFFFC0 | 28'($urandom_range(0, 63));
            if (r < 45) send_req(ACT_ADD, f, n);
            else if (r < 70) send_req(ACT_DEL, f, n);
            else if (r < 97) send_req(ACT_SPAN, f, n);
            else send_req(ACT_NONE, f, n);
        end
        drain();
        repeat (200) @(negedge i_clk);

        $display("covered %0d requests, %0d results checked, adds/deletes/spans with merges,",
            req_count, result_count);
        $display("splits, full table, wrap and disable cases; %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
